// ----- src/kfd_pkg.sv -----
// Shared constants, codes and types for the KISS frame deframer.
package kfd_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 256;

   localparam logic [7:0] SYM_FEND  = 8'hC0;
   localparam logic [7:0] SYM_FESC  = 8'hDB;
   localparam logic [7:0] SYM_TFEND = 8'hDC;
   localparam logic [7:0] SYM_TFESC = 8'hDD;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_OPEN   = 3'd1,
      EV_TYPE   = 3'd2,
      EV_DATA   = 3'd3,
      EV_DONE   = 3'd4,
      EV_EMPTY  = 3'd5,
      EV_BADESC = 3'd6,
      EV_OVER   = 3'd7
   } event_type;

   typedef struct packed {
      logic inside_frame;
      logic escape_pending;
   } flags_type;

   typedef struct packed {
      logic [3:0] held_port;
      logic [3:0] held_kind;
   } held_type;

   typedef struct packed {
      event_type  event_res;
      logic [7:0] payload_byte;
      logic [7:0] payload_offset;
      logic [8:0] frame_length;
   } result_type;

endpackage

// ----- src/kfd_decode.sv -----
// Per-byte KISS decode: next frame state and the result for one item.
module kfd_decode #(
   parameter int unsigned MAX_PAYLOAD = kfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic [7:0]                             rx_byte,
   input  kfd_pkg::flags_type                     flags_cur,
   input  logic [$clog2(MAX_PAYLOAD + 2)-1:0]     count_cur,
   input  kfd_pkg::held_type                      held_cur,
   output kfd_pkg::flags_type                     flags_nxt,
   output logic [$clog2(MAX_PAYLOAD + 2)-1:0]     count_nxt,
   output kfd_pkg::held_type                      held_nxt,
   output kfd_pkg::result_type                    result
);
   import kfd_pkg::*;

   localparam int unsigned CountWidth = $clog2(MAX_PAYLOAD + 2);

   logic [CountWidth-1:0] idx;
   logic [31:0]           idx_wide;
   logic [7:0]            dec_byte;
   logic                  have_byte;

   assign idx      = count_cur - CountWidth'(1);
   assign idx_wide = 32'(idx);

   always_comb begin
      flags_nxt             = flags_cur;
      count_nxt             = count_cur;
      held_nxt              = held_cur;
      result.event_res      = EV_NONE;
      result.payload_byte   = 8'd0;
      result.payload_offset = 8'd0;
      result.frame_length   = 9'd0;
      dec_byte              = rx_byte;
      have_byte             = 1'b0;

      if (rx_byte == SYM_FEND) begin
         if (!flags_cur.inside_frame) begin
            flags_nxt.inside_frame   = 1'b1;
            flags_nxt.escape_pending = 1'b0;
            count_nxt                = '0;
            result.event_res         = EV_OPEN;
         end else if (count_cur != '0) begin
            flags_nxt.inside_frame   = 1'b0;
            flags_nxt.escape_pending = 1'b0;
            result.frame_length      = idx_wide[8:0];
            result.event_res         = EV_DONE;
         end else begin
            flags_nxt.inside_frame   = 1'b0;
            flags_nxt.escape_pending = 1'b0;
            result.event_res         = EV_EMPTY;
         end
      end else if (flags_cur.inside_frame) begin
         if (flags_cur.escape_pending) begin
            flags_nxt.escape_pending = 1'b0;
            if (rx_byte == SYM_TFEND) begin
               dec_byte  = SYM_FEND;
               have_byte = 1'b1;
            end else if (rx_byte == SYM_TFESC) begin
               dec_byte  = SYM_FESC;
               have_byte = 1'b1;
            end else begin
               flags_nxt.inside_frame = 1'b0;
               result.event_res       = EV_BADESC;
            end
         end else if (rx_byte == SYM_FESC) begin
            flags_nxt.escape_pending = 1'b1;
         end else begin
            have_byte = 1'b1;
         end
      end

      if (have_byte) begin
         if (count_cur == '0) begin
            held_nxt.held_port = dec_byte[7:4];
            held_nxt.held_kind = dec_byte[3:0];
            count_nxt          = CountWidth'(1);
            result.event_res   = EV_TYPE;
         end else if (idx_wide >= 32'(MAX_PAYLOAD)) begin
            flags_nxt.inside_frame   = 1'b0;
            flags_nxt.escape_pending = 1'b0;
            result.event_res         = EV_OVER;
         end else begin
            result.payload_byte   = dec_byte;
            result.payload_offset = idx_wide[7:0];
            count_nxt             = count_cur + CountWidth'(1);
            result.event_res      = EV_DATA;
         end
      end
   end

endmodule

// ----- src/kiss_frame_deframer_unit.sv -----
// KISS deframer top level: input register, frame state, result register.
// An item passes through the input register, then the result register,
// whose valid bit drives rsp_valid; rsp_stall can hold it in between.
// Throughput: one item per cycle while rsp_stall is low; the result register drains
// while the input register refills, so back-to-back items flow without bubbles.
// Reset (synchronous, active high): frame closed, no escape, count and held
// port/kind cleared, both pipeline registers empty.
module kiss_frame_deframer_unit #(
   parameter int unsigned MAX_PAYLOAD = kfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_offset,
   output logic [8:0] rsp_frame_length,
   output logic [3:0] rsp_port_number,
   output logic [3:0] rsp_frame_kind
);
   import kfd_pkg::*;

   localparam int unsigned CountWidth = $clog2(MAX_PAYLOAD + 2);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff;
   result_type            result_ff;
   held_type              out_held_ff;

   flags_type             flags_ff;
   flags_type             flags_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   held_type              held_ff;
   held_type              held_in;
   result_type            result_in;

   logic                  advance;
   logic                  load_in;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = req_valid && !req_stall;

   kfd_decode #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_decode (
      .rx_byte   (in_byte_ff),
      .flags_cur (flags_ff),
      .count_cur (count_ff),
      .held_cur  (held_ff),
      .flags_nxt (flags_in),
      .count_nxt (count_in),
      .held_nxt  (held_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
      end else begin
         if (load_in) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            flags_ff     <= flags_in;
            count_ff     <= count_in;
            held_ff      <= held_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         result_ff   <= result_in;
         out_held_ff <= held_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_res      = result_ff.event_res;
   assign rsp_payload_byte   = result_ff.payload_byte;
   assign rsp_payload_offset = result_ff.payload_offset;
   assign rsp_frame_length   = result_ff.frame_length;
   assign rsp_port_number    = out_held_ff.held_port;
   assign rsp_frame_kind     = out_held_ff.held_kind;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the KISS frame deframer: directed, long, stalled and random streams.
module testbench;
   import kfd_pkg::*;

   typedef struct {
      event_type  ev;
      logic [7:0] data;
      logic [7:0] offset;
      logic [8:0] length;
      logic [3:0] port;
      logic [3:0] kind;
   } decoded_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_event_res;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_offset;
   logic [8:0] rsp_frame_length;
   logic [3:0] rsp_port_number;
   logic [3:0] rsp_frame_kind;

   decoded_result_type decoded_queue[$];
   int unsigned     error_count = 0;
   int unsigned     bytes_sent = 0;
   bit              send_idle_on = 1'b0;
   bit              rsp_idle_on = 1'b0;
   int unsigned     hold_req = 0;
   int unsigned     hold_seen = 0;
   int unsigned     hold_left = 0;
   int unsigned     stall_left = 0;

   // deframer state mirror
   bit              frame_open = 1'b0;
   bit              esc_armed = 1'b0;
   int unsigned     frame_count = 0;
   logic [3:0]      cur_port = 4'd0;
   logic [3:0]      cur_kind = 4'd0;

   kiss_frame_deframer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_port_number    (rsp_port_number),
      .rsp_frame_kind     (rsp_frame_kind)
   );

   always #5 clock = ~clock;

   function automatic decoded_result_type deframe_byte(logic [7:0] raw);
      decoded_result_type r;
      logic [7:0]      b;
      int unsigned     idx;
      r.ev = EV_NONE;
      r.data = 8'd0;
      r.offset = 8'd0;
      r.length = 9'd0;
      b = raw;
      if (raw == SYM_FEND) begin
         if (!frame_open) begin
            frame_open = 1'b1;
            esc_armed = 1'b0;
            frame_count = 0;
            r.ev = EV_OPEN;
         end else if (frame_count > 0) begin
            r.length = 9'(frame_count - 1);
            r.ev = EV_DONE;
            frame_open = 1'b0;
            esc_armed = 1'b0;
         end else begin
            r.ev = EV_EMPTY;
            frame_open = 1'b0;
            esc_armed = 1'b0;
         end
      end else if (frame_open) begin
         if (esc_armed) begin
            esc_armed = 1'b0;
            if (b == SYM_TFEND) b = SYM_FEND;
            else if (b == SYM_TFESC) b = SYM_FESC;
            else begin
               r.ev = EV_BADESC;
               frame_open = 1'b0;
            end
         end else if (b == SYM_FESC) begin
            esc_armed = 1'b1;
         end
      end
      if (frame_open && !esc_armed && r.ev == EV_NONE && raw != SYM_FEND) begin
         if (frame_count == 0) begin
            cur_port = b[7:4];
            cur_kind = b[3:0];
            frame_count = 1;
            r.ev = EV_TYPE;
         end else begin
            idx = frame_count - 1;
            if (idx >= MAX_PAYLOAD_DEF) begin
               r.ev = EV_OVER;
               frame_open = 1'b0;
               esc_armed = 1'b0;
            end else begin
               r.ev = EV_DATA;
               r.data = b;
               r.offset = 8'(idx);
               frame_count = frame_count + 1;
            end
         end
      end
      r.port = cur_port;
      r.kind = cur_kind;
      return r;
   endfunction

   // receiver: random stall bursts plus requested long hold-offs
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 40;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      decoded_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_queue.size() == 0) begin
            $error("unexpected result: event_res %0d", rsp_event_res);
            error_count++;
         end else begin
            exp_r = decoded_queue.pop_front();
            if (rsp_event_res !== exp_r.ev) begin
               $error("event_res expected %0d got %0d", exp_r.ev, rsp_event_res);
               error_count++;
            end
            if (rsp_payload_byte !== exp_r.data) begin
               $error("payload_byte expected %0h got %0h", exp_r.data, rsp_payload_byte);
               error_count++;
            end
            if (rsp_payload_offset !== exp_r.offset) begin
               $error("payload_offset expected %0d got %0d", exp_r.offset,
                      rsp_payload_offset);
               error_count++;
            end
            if (rsp_frame_length !== exp_r.length) begin
               $error("frame_length expected %0d got %0d", exp_r.length, rsp_frame_length);
               error_count++;
            end
            if (rsp_port_number !== exp_r.port) begin
               $error("port_number expected %0d got %0d", exp_r.port, rsp_port_number);
               error_count++;
            end
            if (rsp_frame_kind !== exp_r.kind) begin
               $error("frame_kind expected %0d got %0d", exp_r.kind, rsp_frame_kind);
               error_count++;
            end
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      int unsigned gap;
      if (send_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      decoded_queue.push_back(deframe_byte(b));
      bytes_sent++;
   endtask

   // sends a decoded byte with KISS escaping applied
   task automatic send_escaped(logic [7:0] b);
      if (b == SYM_FEND) begin
         send_byte(SYM_FESC);
         send_byte(SYM_TFEND);
      end else if (b == SYM_FESC) begin
         send_byte(SYM_FESC);
         send_byte(SYM_TFESC);
      end else begin
         send_byte(b);
      end
   endtask

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 11))
         0: return SYM_FEND;
         1: return SYM_FESC;
         2: return SYM_TFEND;
         3: return SYM_TFESC;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_bad_escape();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == SYM_TFEND || b == SYM_TFESC || b == SYM_FEND);
      return b;
   endfunction

   task automatic send_frame(int unsigned len);
      send_byte(SYM_FEND);
      send_escaped(pick_data());
      repeat (len) send_escaped(pick_data());
      send_byte(SYM_FEND);
   endtask

   task automatic test_directed();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYM_TFEND);
      send_byte(SYM_FESC);
      send_byte(SYM_FEND);
      send_byte(SYM_FEND);       // empty frame dropped
      send_byte(SYM_FEND);
      send_byte(8'hFF);          // type: port 15, kind 15
      send_byte(8'h00);
      send_escaped(SYM_FEND);
      send_escaped(SYM_FESC);
      send_byte(8'hFF);
      send_byte(SYM_FEND);       // done, length 4
      send_byte(SYM_FEND);
      send_byte(SYM_FESC);
      send_byte(SYM_FEND);       // closes with escape pending
      send_byte(SYM_FEND);
      send_escaped(SYM_FEND);    // escaped type byte
      send_byte(SYM_FESC);
      send_byte(SYM_FESC);       // double escape is bad
      send_byte(8'h41);          // ignored, frame closed
      send_byte(SYM_FEND);
      send_byte(8'h00);          // type: port 0, kind 0
      send_byte(SYM_FESC);
      send_byte(8'h00);          // bad escape
   endtask

   task automatic test_long_frames();
      send_frame(MAX_PAYLOAD_DEF);          // full length
      send_frame(MAX_PAYLOAD_DEF + 1);      // last byte overflows
      send_byte(SYM_FEND);                  // trailing FEND opened a frame; drop it
   endtask

   task automatic test_backpressure();
      send_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_req++;
      send_frame(24);
   endtask

   task automatic test_random_traffic(int unsigned n_items);
      int unsigned start;
      int unsigned pick;
      start = bytes_sent;
      while (bytes_sent - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame($urandom_range(0, 3) == 0 ? $urandom_range(9, 40)
                                                 : $urandom_range(0, 8));
         end else if (pick < 78) begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
               else send_byte(pick_data());
            end
         end else if (pick < 86) begin
            send_byte(SYM_FEND);
            repeat ($urandom_range(0, 4)) send_escaped(pick_data());
            send_byte(SYM_FESC);
            send_byte(pick_bad_escape());
         end else if (pick < 92) begin
            send_byte(SYM_FEND);
            repeat ($urandom_range(0, 3)) send_escaped(pick_data());
            send_byte(SYM_FESC);
            send_byte(SYM_FEND);
         end else begin
            send_byte(SYM_FEND);
            send_byte(SYM_FEND);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      send_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_long_frames();
      test_backpressure();
      send_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_random_traffic(550);
      send_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(150);

      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && decoded_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- kiss_frame_deframer_unit.f -----
src/kfd_pkg.sv
src/kfd_decode.sv
src/kiss_frame_deframer_unit.sv
verif/testbench.sv
